/* rtl/wsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_pkg - websocket unmasker shared types and constants
// Event codes, header field masks and the result word layout.
// ----------------------------------------------------------------------------
package wsu_pkg;

   typedef enum logic [1:0] {
      EV_DATA  = 2'd0,
      EV_CLOSE = 2'd1,
      EV_EMPTY = 2'd2
   } event_kind_type;

   localparam logic [7:0] OPCODE_MASK  = 8'h0F;
   localparam logic [7:0] LEN7_MASK    = 8'h7F;
   localparam logic [6:0] LEN_EXT16    = 7'd126;
   localparam logic [6:0] LEN_EXT64    = 7'd127;
   localparam logic [3:0] OPCODE_CLOSE = 4'd8;
   localparam logic [3:0] OPCODE_CONT  = 4'd0;

   // extended length and mask key byte counts, minus one
   localparam logic [2:0] EXT16_COUNT  = 3'd1;
   localparam logic [2:0] EXT64_COUNT  = 3'd7;
   localparam logic [2:0] MASK_COUNT   = 3'd3;

   typedef struct packed {
      logic [1:0] event_kind;
      logic [7:0] payload_byte;
      logic       message_end;
   } rsp_word_type;

   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } parse_result_type;

endpackage

/* rtl/wsu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_req_if / wsu_rsp_if - valid/ready channels of the unmasker
// Byte input channel and event result channel.
// ----------------------------------------------------------------------------
interface wsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface wsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_kind;
   logic [7:0] payload_byte;
   logic       message_end;

   modport source (output valid, output event_kind, output payload_byte,
                   output message_end, input ready);
   modport sink   (input valid, input event_kind, input payload_byte,
                   input message_end, output ready);
endinterface

/* rtl/wsu_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_parser - frame header parser and payload unmask
// Holds the frame parse state, advances it on each accepted byte and
// forms the result word for that byte.
// ----------------------------------------------------------------------------
module wsu_parser #(
   parameter int LENGTH_WIDTH = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_fire,
   input  logic [7:0]                 in_byte,
   output wsu_pkg::parse_result_type  result
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic                    close_pending_ff, close_pending_in;
   logic [2:0]              hdr_count_ff, hdr_count_in;
   logic [LENGTH_WIDTH-1:0] rem_len_ff, rem_len_in;
   logic [31:0]             mask_key_ff, mask_key_in;
   logic [1:0]              mask_pos_ff, mask_pos_in;

   logic [6:0]              len7;
   logic [3:0]              opcode;
   logic [1:0]              key_slot;
   logic [7:0]              key_byte;
   logic [LENGTH_WIDTH-1:0] rem_dec;

   assign len7     = in_byte[6:0] & wsu_pkg::LEN7_MASK[6:0];
   assign opcode   = in_byte[3:0] & wsu_pkg::OPCODE_MASK[3:0];
   assign key_slot = 2'd3 - hdr_count_ff[1:0];
   assign key_byte = mask_key_ff[{mask_pos_ff, 3'b000} +: 8];
   assign rem_dec  = rem_len_ff - {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      phase_in         = phase_ff;
      close_pending_in = close_pending_ff;
      hdr_count_in     = hdr_count_ff;
      rem_len_in       = rem_len_ff;
      mask_key_in      = mask_key_ff;
      mask_pos_in      = mask_pos_ff;
      result           = '0;

      unique case (phase_ff)
         PH_HDR1: begin
            if (close_pending_ff) begin
               close_pending_in         = 1'b0;
               phase_in                 = PH_HDR0;
               result.emit              = 1'b1;
               result.word.event_kind   = wsu_pkg::EV_CLOSE;
            end else begin
               mask_key_in = '0;
               mask_pos_in = '0;
               if (len7 == wsu_pkg::LEN_EXT16) begin
                  rem_len_in   = '0;
                  hdr_count_in = wsu_pkg::EXT16_COUNT;
                  phase_in     = PH_EXT;
               end else if (len7 == wsu_pkg::LEN_EXT64) begin
                  rem_len_in   = '0;
                  hdr_count_in = wsu_pkg::EXT64_COUNT;
                  phase_in     = PH_EXT;
               end else begin
                  rem_len_in   = {{(LENGTH_WIDTH-7){1'b0}}, len7};
                  hdr_count_in = wsu_pkg::MASK_COUNT;
                  phase_in     = PH_MASK;
               end
            end
         end
         PH_EXT: begin
            // big-endian shift-in, wraps at the register width
            rem_len_in = {rem_len_ff[LENGTH_WIDTH-9:0], in_byte};
            if (hdr_count_ff == 3'd0) begin
               hdr_count_in = wsu_pkg::MASK_COUNT;
               phase_in     = PH_MASK;
            end else begin
               hdr_count_in = hdr_count_ff - 3'd1;
            end
         end
         PH_MASK: begin
            mask_key_in[{key_slot, 3'b000} +: 8] =
               mask_key_ff[{key_slot, 3'b000} +: 8] | in_byte;
            if (hdr_count_ff != 3'd0) begin
               hdr_count_in = hdr_count_ff - 3'd1;
            end else begin
               mask_pos_in = '0;
               if (rem_len_ff == '0) begin
                  phase_in                 = PH_HDR0;
                  result.emit              = 1'b1;
                  result.word.event_kind   = wsu_pkg::EV_EMPTY;
                  result.word.message_end  = 1'b1;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            mask_pos_in              = mask_pos_ff + 2'd1;
            rem_len_in               = rem_dec;
            result.emit              = 1'b1;
            result.word.event_kind   = wsu_pkg::EV_DATA;
            result.word.payload_byte = in_byte ^ key_byte;
            result.word.message_end  = (rem_dec == '0);
            if (rem_dec == '0) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            close_pending_in = (opcode == wsu_pkg::OPCODE_CLOSE) ||
                               (opcode == wsu_pkg::OPCODE_CONT);
            hdr_count_in     = '0;
            phase_in         = PH_HDR1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HDR0;
         close_pending_ff <= 1'b0;
         hdr_count_ff     <= '0;
         rem_len_ff       <= '0;
         mask_key_ff      <= '0;
         mask_pos_ff      <= '0;
      end else if (in_fire) begin
         phase_ff         <= phase_in;
         close_pending_ff <= close_pending_in;
         hdr_count_ff     <= hdr_count_in;
         rem_len_ff       <= rem_len_in;
         mask_key_ff      <= mask_key_in;
         mask_pos_ff      <= mask_pos_in;
      end
   end

endmodule

/* rtl/wsu_out_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsu_out_reg - result register
// Holds one result word until taken; frees up in the cycle it is taken.
// ----------------------------------------------------------------------------
module wsu_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  wsu_pkg::parse_result_type result,
   input  logic                      out_ready,
   output logic                      out_valid,
   output wsu_pkg::rsp_word_type     out_word,
   output logic                      can_load
);

   logic                  valid_ff;
   wsu_pkg::rsp_word_type word_ff;

   assign can_load  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= result.emit;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= result.word;
      end
   end

endmodule

/* rtl/websocket_frame_unmasker.sv */
`timescale 1ns / 1ps
// A result word is formed combinationally and registered in the result register as its byte is accepted.
// Throughput: one byte per cycle; the only stall is a held result the sink has not taken.
// Header, extended length and mask bytes yield no word except close and empty-message events.
// Reset (synchronous): parser returns to frame start, length, mask and counters clear,
// and the result register empties.
// ----------------------------------------------------------------------------
// websocket_frame_unmasker - client-to-server frame deframer and unmasker
// Parses frame headers byte by byte and emits unmasked payload, close and
// empty-message events.
// ----------------------------------------------------------------------------
module websocket_frame_unmasker #(
   parameter int LENGTH_WIDTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   wsu_req_if.sink   req_chan,
   wsu_rsp_if.source rsp_chan
);

   wsu_pkg::parse_result_type result;
   wsu_pkg::rsp_word_type     out_word;
   logic                      in_fire;
   logic                      can_load;

   assign req_chan.ready = can_load;
   assign in_fire        = req_chan.valid && can_load;

   wsu_parser #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .in_byte (req_chan.stream_byte),
      .result  (result)
   );

   wsu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (in_fire),
      .result    (result),
      .out_ready (rsp_chan.ready),
      .out_valid (rsp_chan.valid),
      .out_word  (out_word),
      .can_load  (can_load)
   );

   assign rsp_chan.event_kind   = out_word.event_kind;
   assign rsp_chan.payload_byte = out_word.payload_byte;
   assign rsp_chan.message_end  = out_word.message_end;

   // a byte is only taken when no word is held or the held word leaves in the same cycle
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("input accepted over a held result word");

   a_close_no_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_kind == wsu_pkg::EV_CLOSE) |->
      (!rsp_chan.message_end && rsp_chan.payload_byte == 8'd0))
      else $error("close event carries data or end mark");

   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.event_kind == wsu_pkg::EV_EMPTY) |->
      (rsp_chan.message_end && rsp_chan.payload_byte == 8'd0))
      else $error("empty message without end mark");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.event_kind == wsu_pkg::EV_DATA ||
                          rsp_chan.event_kind == wsu_pkg::EV_CLOSE ||
                          rsp_chan.event_kind == wsu_pkg::EV_EMPTY))
      else $error("undefined event kind on output");

endmodule
